// ===== hw/rtl/green_tetrahedron_splitter_defines.svh =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GREEN_TETRAHEDRON_SPLITTER_DEFINES_SVH
`define GREEN_TETRAHEDRON_SPLITTER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define GTS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define GTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gts_pkg.sv =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter package
// Split kinds, result status codes, id slot positions and fixed sizes.
// ----------------------------------------------------------------------------
package gts_pkg;

    localparam int CELL_BITS = 20;
    localparam logic [CELL_BITS-1:0] CELL_MAX = {CELL_BITS{1'b1}};

    localparam logic [1:0] ST_CHILD = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam int FIFO_DEPTH = 2;

    // Positions of the ids carried from the front to the back.
    localparam int ID_SLOTS = 7;
    localparam int SLOT_A = 0;
    localparam int SLOT_B = 1;
    localparam int SLOT_C = 2;
    localparam int SLOT_D = 3;
    localparam int SLOT_P = 4;
    localparam int SLOT_Q = 5;
    localparam int SLOT_R = 6;

    typedef enum logic [2:0] {
        KIND_ONE,
        KIND_OPP,
        KIND_FACE,
        KIND_SKIP,
        KIND_BAD
    } kind_t;

    localparam int KIND_BITS = $bits(kind_t);

endpackage

// ===== hw/rtl/green_tetrahedron_splitter.sv =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter
// Splits a parent tetrahedron into green children, one per cycle while popped.
// ----------------------------------------------------------------------------
// A parent that is already split or has an unusable midpoint pattern gives one
// result; a parent with one midpoint gives two children, and one with an
// opposite pair or a face triple gives four. The child emitter delivers one
// result per cycle while results are popped, and this emitter sets the
// sustained rate. A two-entry queue behind the input lets new parents arrive
// while children are still going out. A taken parent is written into the
// queue, and the child emitter then registers its first result at the output.
// Cell numbers start at one after reset and stop at the largest 20-bit value.
module green_tetrahedron_splitter
    import gts_pkg::*;
#(
    parameter int NODE_ID_BITS = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [NODE_ID_BITS-1:0] node_i,
    input  logic [NODE_ID_BITS-1:0] node_j,
    input  logic [NODE_ID_BITS-1:0] node_k,
    input  logic [NODE_ID_BITS-1:0] node_l,
    input  logic [NODE_ID_BITS-1:0] mid_ij,
    input  logic [NODE_ID_BITS-1:0] mid_kl,
    input  logic [NODE_ID_BITS-1:0] mid_ik,
    input  logic [NODE_ID_BITS-1:0] mid_il,
    input  logic [NODE_ID_BITS-1:0] mid_jl,
    input  logic [NODE_ID_BITS-1:0] mid_jk,
    input  logic                    already_refined,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              status,
    output logic [NODE_ID_BITS-1:0] vertex_a,
    output logic [NODE_ID_BITS-1:0] vertex_b,
    output logic [NODE_ID_BITS-1:0] vertex_c,
    output logic [NODE_ID_BITS-1:0] vertex_d,
    output logic [CELL_BITS-1:0]    cell_number,
    output logic                    last
);

    localparam int DESC_BITS = KIND_BITS + ID_SLOTS * NODE_ID_BITS;

    logic                                  wr_en;
    kind_t                                 wr_kind;
    logic [ID_SLOTS-1:0][NODE_ID_BITS-1:0] wr_ids;
    logic [DESC_BITS-1:0]                  wr_data;
    logic [DESC_BITS-1:0]                  rd_data;
    logic                                  rd_en;
    logic                                  fifo_empty;
    kind_t                                 head_kind;
    logic [ID_SLOTS-1:0][NODE_ID_BITS-1:0] head_ids;

    gts_front #(
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_front (
        .push            (push),
        .fifo_full       (full),
        .node_i          (node_i),
        .node_j          (node_j),
        .node_k          (node_k),
        .node_l          (node_l),
        .mid_ij          (mid_ij),
        .mid_kl          (mid_kl),
        .mid_ik          (mid_ik),
        .mid_il          (mid_il),
        .mid_jl          (mid_jl),
        .mid_jk          (mid_jk),
        .already_refined (already_refined),
        .wr_en           (wr_en),
        .kind            (wr_kind),
        .ids             (wr_ids)
    );

    assign wr_data = {wr_kind, wr_ids};

    gts_fifo #(
        .WIDTH (DESC_BITS)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_data    (rd_data),
        .fifo_full  (full),
        .fifo_empty (fifo_empty)
    );

    assign head_kind = kind_t'(rd_data[DESC_BITS-1 -: KIND_BITS]);
    assign head_ids  = rd_data[ID_SLOTS*NODE_ID_BITS-1:0];

    gts_back #(
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!fifo_empty),
        .head_kind   (head_kind),
        .head_ids    (head_ids),
        .rd_en       (rd_en),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .vertex_c    (vertex_c),
        .vertex_d    (vertex_d),
        .cell_number (cell_number),
        .last        (last)
    );

endmodule

// ===== hw/rtl/gts_front.sv =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter front end
// Classifies the midpoint pattern of a parent and names its corners.
// ----------------------------------------------------------------------------
module gts_front
    import gts_pkg::*;
#(
    parameter int NODE_ID_BITS = 20
)
(
    input  logic                                   push,
    input  logic                                   fifo_full,
    input  logic [NODE_ID_BITS-1:0]                node_i,
    input  logic [NODE_ID_BITS-1:0]                node_j,
    input  logic [NODE_ID_BITS-1:0]                node_k,
    input  logic [NODE_ID_BITS-1:0]                node_l,
    input  logic [NODE_ID_BITS-1:0]                mid_ij,
    input  logic [NODE_ID_BITS-1:0]                mid_kl,
    input  logic [NODE_ID_BITS-1:0]                mid_ik,
    input  logic [NODE_ID_BITS-1:0]                mid_il,
    input  logic [NODE_ID_BITS-1:0]                mid_jl,
    input  logic [NODE_ID_BITS-1:0]                mid_jk,
    input  logic                                   already_refined,
    output logic                                   wr_en,
    output kind_t                                  kind,
    output logic [ID_SLOTS-1:0][NODE_ID_BITS-1:0]  ids
);

    logic has_ij, has_kl, has_ik, has_il, has_jl, has_jk;
    logic [2:0] mid_count;

    assign wr_en = push && !fifo_full;

    assign has_ij = |mid_ij;
    assign has_kl = |mid_kl;
    assign has_ik = |mid_ik;
    assign has_il = |mid_il;
    assign has_jl = |mid_jl;
    assign has_jk = |mid_jk;

    assign mid_count = {2'b00, has_ij} + {2'b00, has_kl} + {2'b00, has_ik}
                     + {2'b00, has_il} + {2'b00, has_jl} + {2'b00, has_jk};

    always_comb
    begin
        kind = KIND_BAD;
        ids  = '0;
        if (already_refined)
        begin
            kind = KIND_SKIP;
        end
        else
        begin
            case (mid_count)
                3'd1:
                begin
                    kind = KIND_ONE;
                    if (has_ij)
                    begin
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_j;
                        ids[SLOT_C] = node_k; ids[SLOT_D] = node_l;
                        ids[SLOT_P] = mid_ij;
                    end
                    else if (has_ik)
                    begin
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_k;
                        ids[SLOT_C] = node_l; ids[SLOT_D] = node_j;
                        ids[SLOT_P] = mid_ik;
                    end
                    else if (has_il)
                    begin
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_l;
                        ids[SLOT_C] = node_j; ids[SLOT_D] = node_k;
                        ids[SLOT_P] = mid_il;
                    end
                    else if (has_jk)
                    begin
                        ids[SLOT_A] = node_j; ids[SLOT_B] = node_k;
                        ids[SLOT_C] = node_i; ids[SLOT_D] = node_l;
                        ids[SLOT_P] = mid_jk;
                    end
                    else if (has_jl)
                    begin
                        ids[SLOT_A] = node_j; ids[SLOT_B] = node_l;
                        ids[SLOT_C] = node_k; ids[SLOT_D] = node_i;
                        ids[SLOT_P] = mid_jl;
                    end
                    else
                    begin
                        ids[SLOT_A] = node_k; ids[SLOT_B] = node_l;
                        ids[SLOT_C] = node_i; ids[SLOT_D] = node_j;
                        ids[SLOT_P] = mid_kl;
                    end
                end
                3'd2:
                begin
                    if (has_ij && has_kl)
                    begin
                        kind = KIND_OPP;
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_j;
                        ids[SLOT_C] = node_k; ids[SLOT_D] = node_l;
                        ids[SLOT_P] = mid_ij; ids[SLOT_Q] = mid_kl;
                    end
                    else if (has_ik && has_jl)
                    begin
                        kind = KIND_OPP;
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_k;
                        ids[SLOT_C] = node_l; ids[SLOT_D] = node_j;
                        ids[SLOT_P] = mid_ik; ids[SLOT_Q] = mid_jl;
                    end
                    else if (has_il && has_jk)
                    begin
                        kind = KIND_OPP;
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_l;
                        ids[SLOT_C] = node_j; ids[SLOT_D] = node_k;
                        ids[SLOT_P] = mid_il; ids[SLOT_Q] = mid_jk;
                    end
                end
                3'd3:
                begin
                    if (has_ij && has_ik && has_jk)
                    begin
                        kind = KIND_FACE;
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_j;
                        ids[SLOT_C] = node_k; ids[SLOT_D] = node_l;
                        ids[SLOT_P] = mid_ij; ids[SLOT_Q] = mid_ik;
                        ids[SLOT_R] = mid_jk;
                    end
                    else if (has_ij && has_il && has_jl)
                    begin
                        kind = KIND_FACE;
                        ids[SLOT_A] = node_j; ids[SLOT_B] = node_i;
                        ids[SLOT_C] = node_l; ids[SLOT_D] = node_k;
                        ids[SLOT_P] = mid_ij; ids[SLOT_Q] = mid_jl;
                        ids[SLOT_R] = mid_il;
                    end
                    else if (has_ik && has_il && has_kl)
                    begin
                        kind = KIND_FACE;
                        ids[SLOT_A] = node_i; ids[SLOT_B] = node_k;
                        ids[SLOT_C] = node_l; ids[SLOT_D] = node_j;
                        ids[SLOT_P] = mid_ik; ids[SLOT_Q] = mid_il;
                        ids[SLOT_R] = mid_kl;
                    end
                    else if (has_jk && has_jl && has_kl)
                    begin
                        kind = KIND_FACE;
                        ids[SLOT_A] = node_j; ids[SLOT_B] = node_l;
                        ids[SLOT_C] = node_k; ids[SLOT_D] = node_i;
                        ids[SLOT_P] = mid_jl; ids[SLOT_Q] = mid_jk;
                        ids[SLOT_R] = mid_kl;
                    end
                end
                default:
                begin
                    kind = KIND_BAD;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/gts_fifo.sv =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter descriptor queue
// Short register queue between the classifier and the child emitter.
// ----------------------------------------------------------------------------
module gts_fifo
    import gts_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             fifo_full,
    output logic             fifo_empty
);

    localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FIFO_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(FIFO_DEPTH);

    logic [WIDTH-1:0]    mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign fifo_full  = (count_reg == CNT_FULL);
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/gts_back.sv =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter back end
// Emits one child per cycle from the queue head while popped, numbering cells.
// ----------------------------------------------------------------------------
module gts_back
    import gts_pkg::*;
#(
    parameter int NODE_ID_BITS = 20
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   head_valid,
    input  kind_t                                  head_kind,
    input  logic [ID_SLOTS-1:0][NODE_ID_BITS-1:0]  head_ids,
    output logic                                   rd_en,
    input  logic                                   pop,
    output logic                                   empty,
    output logic [1:0]                             status,
    output logic [NODE_ID_BITS-1:0]                vertex_a,
    output logic [NODE_ID_BITS-1:0]                vertex_b,
    output logic [NODE_ID_BITS-1:0]                vertex_c,
    output logic [NODE_ID_BITS-1:0]                vertex_d,
    output logic [CELL_BITS-1:0]                   cell_number,
    output logic                                   last
);

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              idx_reg, idx_next;
    logic [CELL_BITS-1:0]    counter_reg, counter_next;
    logic [1:0]              status_reg;
    logic [NODE_ID_BITS-1:0] va_reg, vb_reg, vc_reg, vd_reg;
    logic [CELL_BITS-1:0]    cell_reg;
    logic                    last_reg;

    logic                    step;
    logic                    is_child;
    logic                    is_last;
    logic [1:0]              idx_final;
    logic [1:0]              st_sel;
    logic [NODE_ID_BITS-1:0] va_sel, vb_sel, vc_sel, vd_sel;
    logic [CELL_BITS-1:0]    cell_inc;

    assign step     = head_valid && (!out_valid_reg || pop);
    assign is_child = (head_kind == KIND_ONE) || (head_kind == KIND_OPP)
                   || (head_kind == KIND_FACE);
    assign is_last  = (idx_reg == idx_final);
    assign rd_en    = step && is_last;
    assign cell_inc = (counter_reg < CELL_MAX) ? counter_reg + 1'b1 : counter_reg;

    always_comb
    begin
        case (head_kind)
            KIND_ONE:  idx_final = 2'd1;
            KIND_OPP:  idx_final = 2'd3;
            KIND_FACE: idx_final = 2'd3;
            default:   idx_final = 2'd0;
        endcase
    end

    always_comb
    begin
        st_sel = ST_CHILD;
        va_sel = '0;
        vb_sel = '0;
        vc_sel = '0;
        vd_sel = '0;
        case (head_kind)
            KIND_ONE:
            begin
                if (idx_reg == 2'd0)
                begin
                    va_sel = head_ids[SLOT_B]; vb_sel = head_ids[SLOT_D];
                    vc_sel = head_ids[SLOT_C]; vd_sel = head_ids[SLOT_P];
                end
                else
                begin
                    va_sel = head_ids[SLOT_A]; vb_sel = head_ids[SLOT_C];
                    vc_sel = head_ids[SLOT_D]; vd_sel = head_ids[SLOT_P];
                end
            end
            KIND_OPP:
            begin
                vc_sel = head_ids[SLOT_P];
                vd_sel = head_ids[SLOT_Q];
                case (idx_reg)
                    2'd0:    begin va_sel = head_ids[SLOT_D]; vb_sel = head_ids[SLOT_B]; end
                    2'd1:    begin va_sel = head_ids[SLOT_B]; vb_sel = head_ids[SLOT_C]; end
                    2'd2:    begin va_sel = head_ids[SLOT_A]; vb_sel = head_ids[SLOT_D]; end
                    default: begin va_sel = head_ids[SLOT_C]; vb_sel = head_ids[SLOT_A]; end
                endcase
            end
            KIND_FACE:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        va_sel = head_ids[SLOT_C]; vb_sel = head_ids[SLOT_D];
                        vc_sel = head_ids[SLOT_Q]; vd_sel = head_ids[SLOT_R];
                    end
                    2'd1:
                    begin
                        va_sel = head_ids[SLOT_B]; vb_sel = head_ids[SLOT_D];
                        vc_sel = head_ids[SLOT_R]; vd_sel = head_ids[SLOT_P];
                    end
                    2'd2:
                    begin
                        va_sel = head_ids[SLOT_A]; vb_sel = head_ids[SLOT_D];
                        vc_sel = head_ids[SLOT_P]; vd_sel = head_ids[SLOT_Q];
                    end
                    default:
                    begin
                        va_sel = head_ids[SLOT_D]; vb_sel = head_ids[SLOT_P];
                        vc_sel = head_ids[SLOT_Q]; vd_sel = head_ids[SLOT_R];
                    end
                endcase
            end
            KIND_SKIP:
            begin
                st_sel = ST_SKIP;
            end
            default:
            begin
                st_sel = ST_BAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        counter_next   = counter_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
            if (is_child)
            begin
                counter_next = cell_inc;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            counter_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg <= st_sel;
            va_reg     <= va_sel;
            vb_reg     <= vb_sel;
            vc_reg     <= vc_sel;
            vd_reg     <= vd_sel;
            cell_reg   <= is_child ? cell_inc : '0;
            last_reg   <= is_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign status      = status_reg;
    assign vertex_a    = va_reg;
    assign vertex_b    = vb_reg;
    assign vertex_c    = vc_reg;
    assign vertex_d    = vd_reg;
    assign cell_number = cell_reg;
    assign last        = last_reg;

endmodule

// ===== hw/rtl/gts_checker.sv =====
// ----------------------------------------------------------------------------
// Green tetrahedron splitter port checker
// Watches the result side of the splitter and flags malformed results.
// ----------------------------------------------------------------------------
`include "green_tetrahedron_splitter_defines.svh"

module gts_checker
    import gts_pkg::*;
#(
    parameter int NODE_ID_BITS = 20
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic [1:0]              status,
    input logic [NODE_ID_BITS-1:0] vertex_a,
    input logic [NODE_ID_BITS-1:0] vertex_d,
    input logic [CELL_BITS-1:0]    cell_number,
    input logic                    last
);

    logic code_ok;
    logic single_out;
    logic single_zero;
    logic waiting;

    assign code_ok     = (status == ST_CHILD) || (status == ST_SKIP) || (status == ST_BAD);
    assign single_out  = !empty && (status != ST_CHILD);
    assign single_zero = (cell_number == '0) && (vertex_a == '0) && (vertex_d == '0);
    assign waiting     = !empty && !pop;

    `GTS_ASSERT_ALWAYS(a_status_code, empty || code_ok, "Result status code is undefined.")
    `GTS_ASSERT_SAME(a_single_last, single_out, last, "A single result is not marked last.")
    `GTS_ASSERT_SAME(a_single_zero, single_out, single_zero, "A single result has nonzero ids.")
    `GTS_ASSERT_NEXT(a_hold_result, waiting, !empty && $stable({cell_number, last}), "Item changed.")

endmodule

bind green_tetrahedron_splitter gts_checker #(
    .NODE_ID_BITS (NODE_ID_BITS)
) u_gts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .vertex_a    (vertex_a),
    .vertex_d    (vertex_d),
    .cell_number (cell_number),
    .last        (last)
);
